// ===== hdl/mso_pkg.sv =====
package mso_pkg;

  // field widths
  localparam int TIME_W    = 64;
  localparam int ADDR_W    = 64;
  localparam int SIZE_W    = 13;
  localparam int TPB_W     = 32;
  localparam int DUR_W     = SIZE_W + TPB_W;
  localparam int RCNT_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  // request kinds
  localparam logic REQ_WINDOW_START = 1'b0;
  localparam logic REQ_ACCESS       = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_BYTE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE0_BASE    = 3'd2;

  // reset value of ticks per byte
  localparam logic [TPB_W-1:0] TPB_RESET = 32'd1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_INACTIVE,
    ST_ACTIVE,
    ST_BAD_CMD,
    ST_OVERLAP,
    ST_OVERFLOW,
    ST_NO_WINDOW
  } status_e;

  // captured request
  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] now;
    logic [ADDR_W-1:0] access_addr;
    logic [SIZE_W-1:0] access_size;
    logic              is_read_or_write;
  } in_item_t;

  // request after duration and range lookup
  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] now;
    logic              is_read_or_write;
    logic [DUR_W-1:0]  duration;
    logic              excluded;
  } prep_t;

  // request after the state update
  typedef struct packed {
    status_e           status;
    logic [TIME_W-1:0] now;
    logic              window_active;
    logic [TIME_W-1:0] app_service_end;
    logic [TIME_W-1:0] scheduled_total;
  } upd_t;

endpackage

// ===== hdl/mso_if.sv =====
interface mso_in_if;
  import mso_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [TIME_W-1:0] now;
  logic [ADDR_W-1:0] access_addr;
  logic [SIZE_W-1:0] access_size;
  logic              is_read_or_write;

  modport source(output valid, req_type, now, access_addr, access_size, is_read_or_write,
                 input ready);
  modport sink(input valid, req_type, now, access_addr, access_size, is_read_or_write,
               output ready);
endinterface

interface mso_out_if;
  import mso_pkg::*;
  logic              valid;
  logic              ready;
  status_e           status;
  logic [TIME_W-1:0] occupied_ticks;

  modport source(output valid, status, occupied_ticks, input ready);
  modport sink(input valid, status, occupied_ticks, output ready);
endinterface

interface mso_cfg_if;
  import mso_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/mso_prep.sv =====
module mso_prep #(
  parameter int NUM_RANGES = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mso_in_if.sink         in_i,
  mso_cfg_if.sink        cfg_i,
  input  logic           adv_i,
  output logic           valid_o,
  output mso_pkg::prep_t prep_o
);
  import mso_pkg::*;

  logic [TPB_W-1:0]  tpb_q;
  logic [RCNT_W-1:0] rcnt_q;
  logic [ADDR_W-1:0] base_q  [NUM_RANGES];
  logic [ADDR_W-1:0] limit_q [NUM_RANGES];

  logic     v1_q, v2_q;
  in_item_t s1_q;
  prep_t    s2_q, s2_d;
  logic     en1, en2;

  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q  <= TPB_RESET;
      rcnt_q <= '0;
      for (int r = 0; r < NUM_RANGES; r++) begin
        base_q[r]  <= '0;
        limit_q[r] <= '0;
      end
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_TICKS_PER_BYTE) begin
        tpb_q <= cfg_i.data[TPB_W-1:0];
      end
      if (cfg_i.index == CFG_RANGE_COUNT) begin
        rcnt_q <= cfg_i.data[RCNT_W-1:0];
      end
      for (int r = 0; r < NUM_RANGES; r++) begin
        if (cfg_i.index == CFG_IDX_W'(CFG_RANGE0_BASE + 2 * r)) begin
          base_q[r] <= cfg_i.data[ADDR_W-1:0];
        end
        if (cfg_i.index == CFG_IDX_W'(CFG_RANGE0_BASE + 2 * r + 1)) begin
          limit_q[r] <= cfg_i.data[ADDR_W-1:0];
        end
      end
    end
  end

  // stage enables
  assign en2        = !v2_q || adv_i;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      s1_q.req_type         <= in_i.req_type;
      s1_q.now              <= in_i.now;
      s1_q.access_addr      <= in_i.access_addr;
      s1_q.access_size      <= in_i.access_size;
      s1_q.is_read_or_write <= in_i.is_read_or_write;
    end
  end

  // service duration and excluded range lookup
  always_comb begin
    s2_d.req_type         = s1_q.req_type;
    s2_d.now              = s1_q.now;
    s2_d.is_read_or_write = s1_q.is_read_or_write;
    s2_d.duration         = DUR_W'(s1_q.access_size) * DUR_W'(tpb_q);
    s2_d.excluded         = 1'b0;
    for (int r = 0; r < NUM_RANGES; r++) begin
      if (RCNT_W'(r) < rcnt_q && s1_q.access_addr >= base_q[r] &&
          s1_q.access_addr < limit_q[r]) begin
        s2_d.excluded = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = v2_q;
  assign prep_o  = s2_q;

endmodule

// ===== hdl/mso_update.sv =====
module mso_update (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mso_pkg::prep_t prep_i,
  output logic           adv_o,
  input  logic           adv_i,
  output logic           valid_o,
  output mso_pkg::upd_t  upd_o
);
  import mso_pkg::*;

  logic              active_q, active_d;
  logic [TIME_W-1:0] se_q, se_d;
  logic [TIME_W-1:0] ae_q, ae_d;
  logic [TIME_W-1:0] tot_q, tot_d;
  logic [TIME_W:0]   end_sum, tot_sum;
  status_e           status;
  logic              v3_q, en3, commit;
  upd_t              s3_q, s3_d;

  assign en3    = !v3_q || adv_i;
  assign adv_o  = en3;
  assign commit = valid_i && en3;

  assign end_sum = {1'b0, prep_i.now} + (TIME_W + 1)'(prep_i.duration);
  assign tot_sum = {1'b0, tot_q} + (TIME_W + 1)'(prep_i.duration);

  // window and service bookkeeping
  always_comb begin
    active_d = active_q;
    se_d     = se_q;
    ae_d     = ae_q;
    tot_d    = tot_q;
    status   = ST_OK;
    if (prep_i.req_type == REQ_WINDOW_START) begin
      if (active_q) begin
        status = ST_ACTIVE;
      end else begin
        active_d = 1'b1;
        se_d     = prep_i.now;
        ae_d     = prep_i.now;
      end
    end else if (!active_q) begin
      status = ST_INACTIVE;
    end else if (!prep_i.is_read_or_write) begin
      status = ST_BAD_CMD;
    end else if (prep_i.now < se_q) begin
      status = ST_OVERLAP;
    end else if (end_sum[TIME_W] || tot_sum[TIME_W]) begin
      status = ST_OVERFLOW;
    end else begin
      se_d = end_sum[TIME_W-1:0];
      if (!prep_i.excluded) begin
        ae_d  = end_sum[TIME_W-1:0];
        tot_d = tot_sum[TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      se_q     <= '0;
      ae_q     <= '0;
      tot_q    <= '0;
      v3_q     <= 1'b0;
    end else begin
      if (commit) begin
        active_q <= active_d;
        se_q     <= se_d;
        ae_q     <= ae_d;
        tot_q    <= tot_d;
      end
      if (en3) begin
        v3_q <= valid_i;
      end
    end
  end

  // carry the updated state to the result stage
  always_comb begin
    s3_d.status          = status;
    s3_d.now             = prep_i.now;
    s3_d.window_active   = active_d;
    s3_d.app_service_end = ae_d;
    s3_d.scheduled_total = tot_d;
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      s3_q <= s3_d;
    end
  end

  assign valid_o = v3_q;
  assign upd_o   = s3_q;

endmodule

// ===== hdl/mso_result.sv =====
module mso_result (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  mso_pkg::upd_t upd_i,
  output logic          adv_o,
  mso_out_if.source     out_o
);
  import mso_pkg::*;

  logic              vo_q, en_out;
  status_e           status_q;
  logic [TIME_W-1:0] occ_q, occ_d;

  assign en_out = !vo_q || out_o.ready;
  assign adv_o  = en_out;

  // occupied ticks: zero while no window is open, else total minus application service still pending
  always_comb begin
    if (!upd_i.window_active) begin
      occ_d = '0;
    end else if (upd_i.app_service_end > upd_i.now) begin
      occ_d = upd_i.scheduled_total + upd_i.now - upd_i.app_service_end;
    end else begin
      occ_d = upd_i.scheduled_total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_out) begin
      vo_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && valid_i) begin
      status_q <= upd_i.status;
      occ_q    <= occ_d;
    end
  end

  assign out_o.valid          = vo_q;
  assign out_o.status         = status_q;
  assign out_o.occupied_ticks = occ_q;

endmodule

// ===== hdl/memory_service_occupancy_monitor.sv =====
// path: a request accepted into the input register passes the lookup, state and result
// registers before its result shows; a stalled output holds it back
// throughput: one request per cycle when the output is not stalled; the window state
// is updated in the single state stage, so back to back requests see each other's effect
// reset: clears window state and pipeline valids, configuration to its reset values
module memory_service_occupancy_monitor #(
  parameter int NUM_RANGES = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mso_in_if.sink    in_i,
  mso_cfg_if.sink   cfg_i,
  mso_out_if.source out_o
);
  import mso_pkg::*;

  logic  prep_valid, upd_valid;
  logic  upd_adv, res_adv;
  prep_t prep;
  upd_t  upd;

  // duration and range lookup
  mso_prep #(
    .NUM_RANGES(NUM_RANGES)
  ) u_prep (
    .clk_i,
    .rst_ni,
    .in_i,
    .cfg_i,
    .adv_i  (upd_adv),
    .valid_o(prep_valid),
    .prep_o (prep)
  );

  // window state update
  mso_update u_update (
    .clk_i,
    .rst_ni,
    .valid_i(prep_valid),
    .prep_i (prep),
    .adv_o  (upd_adv),
    .adv_i  (res_adv),
    .valid_o(upd_valid),
    .upd_o  (upd)
  );

  // occupancy and output register
  mso_result u_result (
    .clk_i,
    .rst_ni,
    .valid_i(upd_valid),
    .upd_i  (upd),
    .adv_o  (res_adv),
    .out_o
  );

endmodule

// ===== hdl/mso_checker.sv =====
module mso_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [2:0]                out_status_i,
  input logic [mso_pkg::TIME_W-1:0] out_occupied_i
);
  import mso_pkg::*;

  logic [2:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 3'd1;
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_status_i) && $stable(out_occupied_i))
    else $error("stalled result changed");

  a_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more requests in flight than pipeline stages");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 3'd0)
    else $error("result without a request");

  a_inactive_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_INACTIVE |-> out_occupied_i == '0)
    else $error("occupancy reported while window closed");

endmodule

bind memory_service_occupancy_monitor mso_checker u_mso_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_occupied_i(out_o.occupied_ticks)
);
